// ----- design/swik_pkg.sv -----
// ----------------------------------------------------------------------------
// swik_pkg
// shared constants, datapath opcodes and the cordic arctangent table
// ----------------------------------------------------------------------------
package swik_pkg;

	localparam int CORDIC_STEPS = 16;
	localparam int ROOT_STEPS   = 32;
	localparam int WRAP_STEPS   = 9;
	localparam int CNT_W        = 5;

	localparam logic [31:0] CENTER_GAIN_RST = 32'h0001_0000;
	localparam logic [34:0] DEG90   = 35'd5898240;
	localparam logic [34:0] DEG180  = 35'd11796480;
	localparam logic [34:0] DEG360  = 35'd23592960;

	localparam logic [7:0] REG_CENTER_GAIN = 8'd0;
	localparam logic [7:0] REG_HALF_LENGTH = 8'd1;
	localparam logic [7:0] REG_HALF_WIDTH  = 8'd2;
	localparam logic [7:0] REG_FLIP_ENABLE = 8'd3;

	typedef enum logic [3:0] {
		OP_NONE,
		OP_LOAD,
		OP_KL,
		OP_KW,
		OP_RL,
		OP_RW,
		OP_COMB,
		OP_SQX,
		OP_SQY,
		OP_ROOT,
		OP_CINIT,
		OP_CITER,
		OP_WINIT,
		OP_WITER,
		OP_FIN
	} op_t;

	typedef struct packed {
		op_t              op;
		logic [CNT_W-1:0] step;
	} dp_cmd_t;

	typedef struct packed {
		logic [31:0] center_gain;
		logic [31:0] half_length;
		logic [31:0] half_width;
		logic        flip_enable;
	} cfg_t;

	function automatic logic [31:0] atan_deg(input logic [CNT_W-1:0] i);
		logic [31:0] r;
		case (i)
			5'd0:    r = 32'd2949120;
			5'd1:    r = 32'd1740967;
			5'd2:    r = 32'd919879;
			5'd3:    r = 32'd466945;
			5'd4:    r = 32'd234379;
			5'd5:    r = 32'd117304;
			5'd6:    r = 32'd58666;
			5'd7:    r = 32'd29335;
			5'd8:    r = 32'd14668;
			5'd9:    r = 32'd7334;
			5'd10:   r = 32'd3667;
			5'd11:   r = 32'd1833;
			5'd12:   r = 32'd917;
			5'd13:   r = 32'd458;
			5'd14:   r = 32'd229;
			5'd15:   r = 32'd115;
			5'd16:   r = 32'd57;
			5'd17:   r = 32'd29;
			5'd18:   r = 32'd14;
			5'd19:   r = 32'd7;
			5'd20:   r = 32'd4;
			5'd21:   r = 32'd2;
			5'd22:   r = 32'd1;
			default: r = 32'd0;
		endcase
		return r;
	endfunction

endpackage

// ----- design/swik_ctrl.sv -----
// ----------------------------------------------------------------------------
// swik_ctrl
// sequencer: steps the datapath through products, root, cordic and wrap
// ----------------------------------------------------------------------------
module swik_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              s_tvalid,
	output logic              s_tready,
	output logic              m_tvalid,
	input  logic              m_tready,
	output swik_pkg::dp_cmd_t cmd
);
	import swik_pkg::*;

	typedef enum logic [13:0] {
		ST_IDLE  = 14'b00000000000001,
		ST_KL    = 14'b00000000000010,
		ST_KW    = 14'b00000000000100,
		ST_RL    = 14'b00000000001000,
		ST_RW    = 14'b00000000010000,
		ST_COMB  = 14'b00000000100000,
		ST_SQX   = 14'b00000001000000,
		ST_SQY   = 14'b00000010000000,
		ST_ROOT  = 14'b00000100000000,
		ST_CINIT = 14'b00001000000000,
		ST_CITER = 14'b00010000000000,
		ST_WINIT = 14'b00100000000000,
		ST_WITER = 14'b01000000000000,
		ST_FIN   = 14'b10000000000000
	} state_t;

	state_t           state_q, state_d;
	logic [CNT_W-1:0] cnt_q, cnt_d;
	logic             fin_go;

	assign s_tready = (state_q == ST_IDLE);
	assign fin_go   = (state_q == ST_FIN) && (!m_tvalid || m_tready);

	always_comb begin
		state_d = state_q;
		cnt_d   = cnt_q;
		cmd.op  = OP_NONE;
		cmd.step = cnt_q;
		case (state_q)
			ST_IDLE: begin
				if (s_tvalid) begin
					cmd.op  = OP_LOAD;
					state_d = ST_KL;
				end
			end
			ST_KL: begin
				cmd.op  = OP_KL;
				state_d = ST_KW;
			end
			ST_KW: begin
				cmd.op  = OP_KW;
				state_d = ST_RL;
			end
			ST_RL: begin
				cmd.op  = OP_RL;
				state_d = ST_RW;
			end
			ST_RW: begin
				cmd.op  = OP_RW;
				state_d = ST_COMB;
			end
			ST_COMB: begin
				cmd.op  = OP_COMB;
				state_d = ST_SQX;
			end
			ST_SQX: begin
				cmd.op  = OP_SQX;
				state_d = ST_SQY;
			end
			ST_SQY: begin
				cmd.op  = OP_SQY;
				cnt_d   = '0;
				state_d = ST_ROOT;
			end
			ST_ROOT: begin
				cmd.op = OP_ROOT;
				cnt_d  = cnt_q + 1'b1;
				if (cnt_q == CNT_W'(ROOT_STEPS - 1)) begin
					state_d = ST_CINIT;
				end
			end
			ST_CINIT: begin
				cmd.op  = OP_CINIT;
				cnt_d   = '0;
				state_d = ST_CITER;
			end
			ST_CITER: begin
				cmd.op = OP_CITER;
				cnt_d  = cnt_q + 1'b1;
				if (cnt_q == CNT_W'(CORDIC_STEPS - 1)) begin
					state_d = ST_WINIT;
				end
			end
			ST_WINIT: begin
				cmd.op  = OP_WINIT;
				cnt_d   = '0;
				state_d = ST_WITER;
			end
			ST_WITER: begin
				cmd.op = OP_WITER;
				cnt_d  = cnt_q + 1'b1;
				if (cnt_q == CNT_W'(WRAP_STEPS - 1)) begin
					state_d = ST_FIN;
				end
			end
			ST_FIN: begin
				if (fin_go) begin
					cmd.op  = OP_FIN;
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			cnt_q    <= '0;
			m_tvalid <= 1'b0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
			if (fin_go) begin
				m_tvalid <= 1'b1;
			end else if (m_tready) begin
				m_tvalid <= 1'b0;
			end
		end
	end

endmodule

// ----- design/swik_dp.sv -----
// ----------------------------------------------------------------------------
// swik_dp
// datapath: shared multiplier, bit-serial root, cordic, angle wrap, heading store
// ----------------------------------------------------------------------------
module swik_dp (
	input  logic              clk,
	input  logic              arst_n,
	input  swik_pkg::dp_cmd_t cmd,
	input  swik_pkg::cfg_t    cfg,
	input  logic [135:0]      in_data,
	output logic [63:0]       out_data,
	output logic              out_held
);
	import swik_pkg::*;

	logic [1:0]         idx_q;
	logic signed [31:0] vx_q, vy_q, om_q, pres_q;
	logic [31:0]        kl_q, kw_q;
	logic signed [48:0] rl_q, rw_q;
	logic signed [31:0] wx_q, wy_q;
	logic [63:0]        sq_q, rem_q, root_q;
	logic signed [35:0] cx_q, cy_q;
	logic signed [31:0] cz_q;
	logic signed [31:0] last_q [4];
	logic               held_q, neg_q;
	logic [34:0]        u_q;

	logic [31:0]        op_a, op_b, om_abs, wx_abs, wy_abs;
	logic [63:0]        prod;
	logic [48:0]        prod_hi;
	logic signed [49:0] wx_w, wy_w;
	logic [63:0]        bitv, trial;
	logic signed [35:0] xs, ys;
	logic [4:0]         sh;
	logic signed [31:0] head;
	logic signed [33:0] delta;
	logic [3:0]         wj;
	logic [34:0]        wm;
	logic signed [35:0] d0, d1, fsum;
	logic signed [32:0] sp0, sp1;

	assign om_abs  = om_q[31] ? 32'(-om_q) : om_q;
	assign wx_abs  = wx_q[31] ? 32'(-wx_q) : wx_q;
	assign wy_abs  = wy_q[31] ? 32'(-wy_q) : wy_q;
	assign prod_hi = {1'b0, prod[63:16]};

	always_comb begin
		case (cmd.op)
			OP_KL:   begin op_a = cfg.center_gain; op_b = cfg.half_length; end
			OP_KW:   begin op_a = cfg.center_gain; op_b = cfg.half_width; end
			OP_RL:   begin op_a = kl_q; op_b = om_abs; end
			OP_RW:   begin op_a = kw_q; op_b = om_abs; end
			OP_SQX:  begin op_a = wx_abs; op_b = wx_abs; end
			default: begin op_a = wy_abs; op_b = wy_abs; end
		endcase
		prod = {32'd0, op_a} * {32'd0, op_b};
	end

	always_comb begin
		if (idx_q <= 2'd1) begin
			wx_w = 50'(vx_q) - 50'(rl_q);
		end else begin
			wx_w = 50'(vx_q) + 50'(rl_q);
		end
		if (idx_q == 2'd0 || idx_q == 2'd3) begin
			wy_w = 50'(vy_q) + 50'(rw_q);
		end else begin
			wy_w = 50'(vy_q) - 50'(rw_q);
		end
	end

	assign bitv  = 64'd1 << (7'd62 - {1'b0, cmd.step, 1'b0});
	assign trial = root_q + bitv;

	assign sh = cmd.step;
	assign xs = cx_q >>> sh;
	assign ys = cy_q >>> sh;

	assign head  = (root_q == 64'd0) ? last_q[idx_q] : cz_q;
	assign delta = 34'(head) - 34'(pres_q);
	assign wj    = 4'(WRAP_STEPS - 1) - cmd.step[3:0];
	assign wm    = DEG360 << wj;

	always_comb begin
		if (neg_q) begin
			d0 = 36'(DEG180) - 36'(u_q);
		end else begin
			d0 = 36'(u_q) - 36'(DEG180);
		end
		if (root_q > 64'h7FFF_FFFF) begin
			sp0 = 33'h0_7FFF_FFFF;
		end else begin
			sp0 = 33'(root_q[31:0]);
		end
		d1  = d0;
		sp1 = sp0;
		if (cfg.flip_enable && (d0 > $signed(36'(DEG90)) || d0 < -$signed(36'(DEG90)))) begin
			d1  = (d0 > 0) ? d0 - 36'(DEG180) : d0 + 36'(DEG180);
			sp1 = -sp0;
		end
		fsum = 36'(pres_q) + d1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 4; i++) begin
				last_q[i] <= '0;
			end
		end else if (cmd.op == OP_WINIT) begin
			last_q[idx_q] <= head;
		end
	end

	always_ff @(posedge clk) begin
		case (cmd.op)
			OP_LOAD: begin
				idx_q  <= in_data[1:0];
				vx_q   <= in_data[33:2];
				vy_q   <= in_data[65:34];
				om_q   <= in_data[97:66];
				pres_q <= in_data[129:98];
			end
			OP_KL: kl_q <= (prod[63:48] != 16'd0) ? 32'hFFFF_FFFF : prod[47:16];
			OP_KW: kw_q <= (prod[63:48] != 16'd0) ? 32'hFFFF_FFFF : prod[47:16];
			OP_RL: rl_q <= om_q[31] ? -$signed(prod_hi) : $signed(prod_hi);
			OP_RW: rw_q <= om_q[31] ? -$signed(prod_hi) : $signed(prod_hi);
			OP_COMB: begin
				if (wx_w > 50'sh7FFF_FFFF) begin
					wx_q <= 32'sh7FFF_FFFF;
				end else if (wx_w < -50'sh8000_0000) begin
					wx_q <= 32'sh8000_0000;
				end else begin
					wx_q <= 32'(wx_w);
				end
				if (wy_w > 50'sh7FFF_FFFF) begin
					wy_q <= 32'sh7FFF_FFFF;
				end else if (wy_w < -50'sh8000_0000) begin
					wy_q <= 32'sh8000_0000;
				end else begin
					wy_q <= 32'(wy_w);
				end
			end
			OP_SQX: sq_q <= prod;
			OP_SQY: begin
				rem_q  <= sq_q + prod;
				root_q <= '0;
			end
			OP_ROOT: begin
				if (rem_q >= trial) begin
					rem_q  <= rem_q - trial;
					root_q <= (root_q >> 1) + bitv;
				end else begin
					root_q <= root_q >> 1;
				end
			end
			OP_CINIT: begin
				if (wx_q < 0) begin
					cx_q <= -36'(wx_q);
					cy_q <= -36'(wy_q);
					cz_q <= (wy_q >= 0) ? 32'(DEG180) : -32'(DEG180);
				end else begin
					cx_q <= 36'(wx_q);
					cy_q <= 36'(wy_q);
					cz_q <= '0;
				end
			end
			OP_CITER: begin
				if (cy_q > 0) begin
					cx_q <= cx_q + ys;
					cy_q <= cy_q - xs;
					cz_q <= cz_q + $signed(atan_deg(cmd.step));
				end else if (cy_q < 0) begin
					cx_q <= cx_q - ys;
					cy_q <= cy_q + xs;
					cz_q <= cz_q - $signed(atan_deg(cmd.step));
				end
			end
			OP_WINIT: begin
				held_q <= (root_q == 64'd0);
				if (delta < -$signed(34'(DEG180))) begin
					neg_q <= 1'b1;
					u_q   <= 35'(-35'(delta) + 35'(DEG180));
				end else begin
					neg_q <= 1'b0;
					u_q   <= 35'(35'(delta) + 35'(DEG180));
				end
			end
			OP_WITER: begin
				if (u_q > wm) begin
					u_q <= u_q - wm;
				end
			end
			OP_FIN: begin
				out_data[31:0] <= sp1[31:0];
				if (fsum > 36'sh7FFF_FFFF) begin
					out_data[63:32] <= 32'h7FFF_FFFF;
				end else if (fsum < -36'sh8000_0000) begin
					out_data[63:32] <= 32'h8000_0000;
				end else begin
					out_data[63:32] <= fsum[31:0];
				end
				out_held <= held_q;
			end
			default: ;
		endcase
	end

endmodule

// ----- design/swerve_inverse_kinematics.sv -----
// ----------------------------------------------------------------------------
// swerve_inverse_kinematics
// accepts one input word at a time and takes the next only once the last
// result is in the output register; the 32-step root, 16-step cordic and
// 9-step wrap share one sequenced datapath. reset: control and config
// registers and all four stored headings clear at once, no sweep
// ----------------------------------------------------------------------------
module swerve_inverse_kinematics (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         cfg_valid,
	output logic         cfg_ready,
	input  logic [7:0]   cfg_index,
	input  logic [31:0]  cfg_data,
	input  logic         s_tvalid,
	output logic         s_tready,
	// module_index, target_vx, target_vy, target_omega, present_angle, zero pad
	input  logic [135:0] s_tdata,
	output logic         m_tvalid,
	input  logic         m_tready,
	// wheel_speed, steer_angle
	output logic [63:0]  m_tdata,
	// angle_held
	output logic         m_tuser
);
	import swik_pkg::*;

	cfg_t    cfg_q;
	dp_cmd_t cmd;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.center_gain <= CENTER_GAIN_RST;
			cfg_q.half_length <= '0;
			cfg_q.half_width  <= '0;
			cfg_q.flip_enable <= 1'b0;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_CENTER_GAIN: cfg_q.center_gain <= cfg_data;
				REG_HALF_LENGTH: cfg_q.half_length <= cfg_data;
				REG_HALF_WIDTH:  cfg_q.half_width  <= cfg_data;
				REG_FLIP_ENABLE: cfg_q.flip_enable <= cfg_data[0];
				default: ;
			endcase
		end
	end

	swik_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.cmd      (cmd)
	);

	swik_dp u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.cfg      (cfg_q),
		.in_data  (s_tdata),
		.out_data (m_tdata),
		.out_held (m_tuser)
	);

`ifndef SYNTHESIS
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("input taken while busy");
	a_held_zero_speed: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser |-> m_tdata[31:0] == 32'd0)
		else $error("held angle with nonzero speed");
	a_result_after_work: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> $past(!s_tready))
		else $error("result without work");
`endif

endmodule

// ----- dv/swerve_inverse_kinematics_tb.sv -----
// ----------------------------------------------------------------------------
// swerve_inverse_kinematics_tb
// drives chassis twists for all four corners through several register
// settings, predicts wheel speed, steering command and the hold flag in a
// scoreboard and checks every output word in order
// ----------------------------------------------------------------------------
module swerve_inverse_kinematics_tb;
	timeunit 1ns;
	timeprecision 1ps;
	import swik_pkg::*;

	typedef struct packed {
		logic [31:0] speed;
		logic [31:0] angle;
		logic        held;
	} wheel_cmd_t;

	class steer_scoreboard;
		logic [31:0] gain, hlen, hwid;
		logic        flip;
		longint      heading [4];
		wheel_cmd_t  pending [$];
		int          errors;

		function new();
			gain = CENTER_GAIN_RST;
			hlen = 0;
			hwid = 0;
			flip = 0;
			errors = 0;
			foreach (heading[i]) heading[i] = 0;
		endfunction

		function void write_reg(logic [7:0] idx, logic [31:0] val);
			case (idx)
				REG_CENTER_GAIN: gain = val;
				REG_HALF_LENGTH: hlen = val;
				REG_HALF_WIDTH:  hwid = val;
				REG_FLIP_ENABLE: flip = val[0];
				default: ;
			endcase
		endfunction

		function longint sat(longint v);
			if (v > 64'sd2147483647) return 64'sd2147483647;
			if (v < -64'sd2147483648) return -64'sd2147483648;
			return v;
		endfunction

		function longint yaw_term(logic [31:0] h, longint om);
			logic [63:0] k, m, a;
			k = ({32'd0, gain} * {32'd0, h}) >> 16;
			if (k > 64'hFFFF_FFFF) k = 64'hFFFF_FFFF;
			a = om < 0 ? -om : om;
			m = (k * a) >> 16;
			return om < 0 ? -longint'(m) : longint'(m);
		endfunction

		function longint floor_shift(longint v, int s);
			return v >>> s;
		endfunction

		function longint heading_of(longint y, longint x);
			longint z, xs, ys;
			z = 0;
			if (x < 0) begin
				z = (y >= 0) ? longint'(DEG180) : -longint'(DEG180);
				x = -x;
				y = -y;
			end
			for (int i = 0; i < CORDIC_STEPS; i++) begin
				xs = floor_shift(x, i);
				ys = floor_shift(y, i);
				if (y > 0) begin
					x += ys; y -= xs; z += longint'(atan_deg(CNT_W'(i)));
				end else if (y < 0) begin
					x -= ys; y += xs; z -= longint'(atan_deg(CNT_W'(i)));
				end
			end
			return z;
		endfunction

		function logic [63:0] root(logic [63:0] n);
			logic [63:0] r, b;
			r = 0;
			b = 64'd1 << 62;
			while (b > n) b >>= 2;
			while (b != 0) begin
				if (n >= r + b) begin
					n -= r + b;
					r = (r >> 1) + b;
				end else r >>= 1;
				b >>= 2;
			end
			return r;
		endfunction

		function void note_twist(logic [135:0] d);
			logic [1:0] idx;
			longint vx, vy, om, cur, rl, rw, wx, wy, spd, cmd, dl, k, d180, d360, d90;
			wheel_cmd_t e;
			d90 = DEG90; d180 = DEG180; d360 = DEG360;
			idx = d[1:0];
			vx = signed'(d[33:2]);
			vy = signed'(d[65:34]);
			om = signed'(d[97:66]);
			cur = signed'(d[129:98]);
			rl = yaw_term(hlen, om);
			rw = yaw_term(hwid, om);
			wx = sat(idx <= 1 ? vx - rl : vx + rl);
			wy = sat((idx == 0 || idx == 3) ? vy + rw : vy - rw);
			spd = longint'(root(wx * wx + wy * wy));
			if (spd > 64'sd2147483647) spd = 64'sd2147483647;
			e.held = (spd == 0);
			cmd = e.held ? heading[idx] : heading_of(wy, wx);
			heading[idx] = cmd;
			dl = cmd - cur;
			if (dl > d180) begin
				k = (dl - d180 + d360 - 1) / d360;
				dl -= k * d360;
			end else if (dl < -d180) begin
				k = (-d180 - dl + d360 - 1) / d360;
				dl += k * d360;
			end
			if (flip && (dl > d90 || dl < -d90)) begin
				dl += (dl > 0) ? -d180 : d180;
				spd = -spd;
			end
			e.speed = spd[31:0];
			e.angle = 32'(sat(cur + dl));
			pending.push_back(e);
		endfunction

		function void check_word(logic [63:0] d, logic u);
			wheel_cmd_t e;
			if (pending.size() == 0) begin
				$display("%0t: unexpected word %h %b", $time, d, u);
				errors++;
				return;
			end
			e = pending.pop_front();
			if (d[31:0] !== e.speed)
				$display("%0t: wheel_speed exp %h got %h", $time, e.speed, d[31:0]);
			if (d[63:32] !== e.angle)
				$display("%0t: steer_angle exp %h got %h", $time, e.angle, d[63:32]);
			if (u !== e.held)
				$display("%0t: angle_held exp %b got %b", $time, e.held, u);
			if (d[31:0] !== e.speed || d[63:32] !== e.angle || u !== e.held) errors++;
		endfunction
	endclass

	logic         clk = 0;
	logic         arst_n = 0;
	logic         cfg_valid = 0;
	logic         cfg_ready;
	logic [7:0]   cfg_index = 0;
	logic [31:0]  cfg_data = 0;
	logic         s_tvalid = 0;
	logic         s_tready;
	logic [135:0] s_tdata = 0;
	logic         m_tvalid;
	logic         m_tready = 0;
	logic [63:0]  m_tdata;
	logic         m_tuser;
	int           hold_off = 0;
	bit           sent_all = 0;

	steer_scoreboard sb = new();

	swerve_inverse_kinematics i_dut (.*);

	always #2 clk = ~clk;

	function automatic int gap();
		return ($urandom_range(0, 9) == 0) ? $urandom_range(5, 60) :
			(($urandom_range(0, 2) == 0) ? $urandom_range(0, 3) : 0);
	endfunction

	task automatic write_reg(logic [7:0] idx, logic [31:0] val);
		cfg_valid <= 1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		sb.write_reg(idx, val);
		cfg_valid <= 0;
		@(posedge clk);
	endtask

	task automatic send(logic [1:0] idx, logic [31:0] vx, logic [31:0] vy,
			logic [31:0] om, logic [31:0] cur, bit pace);
		int g;
		g = pace ? gap() : 0;
		repeat (g) @(posedge clk);
		s_tvalid <= 1;
		s_tdata <= {6'd0, cur, om, vy, vx, idx};
		do @(posedge clk); while (!s_tready);
		sb.note_twist({6'd0, cur, om, vy, vx, idx});
		s_tvalid <= 0;
		@(posedge clk);
	endtask

	task automatic drain();
		while (sb.pending.size() != 0) @(posedge clk);
		repeat (80) @(posedge clk);
	endtask

	function automatic logic [31:0] rnd_val();
		case ($urandom_range(0, 5))
			0: return 0;
			1: return $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
			2: return $urandom_range(0, 2 * 65536 * 4) - 65536 * 4;
			3: return $urandom();
			default: return $urandom_range(0, 20 * 65536) - 10 * 65536;
		endcase
	endfunction

	function automatic logic [31:0] rnd_geom();
		case ($urandom_range(0, 3))
			0: return 0;
			1: return 32'hFFFF_FFFF;
			default: return $urandom_range(0, 2 * 65536);
		endcase
	endfunction

	always @(posedge clk) begin
		if (m_tvalid && m_tready) sb.check_word(m_tdata, m_tuser);
	end

	initial begin
		int g;
		forever begin
			@(posedge clk);
			if (hold_off > 0) begin
				hold_off--;
				m_tready <= 0;
			end else begin
				g = $urandom_range(0, 7) == 0 ? gap() : 0;
				if (g > 0) begin
					m_tready <= 0;
					repeat (g - 1) @(posedge clk);
				end else begin
					m_tready <= 1;
				end
			end
		end
	end

	initial begin
		#8ms;
		$display("swerve_inverse_kinematics_tb: errors");
		$finish;
	end

	initial begin
		repeat (8) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);
		// zero twist holds the stored heading, then axis and extreme vectors
		for (int m = 0; m < 4; m++) send(2'(m), 0, 0, 0, 32'd90 << 16, 0);
		send(0, 32'h0001_0000, 0, 0, 0, 1);
		send(1, 32'hFFFF_0000, 0, 0, 0, 1);
		send(2, 32'hFFFF_0000, 32'hFFFF_FFFF, 0, 0, 1);
		send(3, 0, 32'h0001_0000, 0, 32'h7FFF_FFFF, 1);
		send(0, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 0, 32'h8000_0000, 0);
		send(1, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 32'd720 << 16, 0);
		send(2, 0, 0, 32'h8000_0000, 32'hFD30_0000, 0);
		send(3, 0, 32'hFFFF_0000, 0, 32'd170 << 16, 0);
		drain();
		write_reg(REG_FLIP_ENABLE, 1);
		write_reg(REG_HALF_LENGTH, 32'h0000_8000);
		write_reg(REG_HALF_WIDTH, 32'h0000_6000);
		write_reg(REG_CENTER_GAIN, 32'h0002_0000);
		for (int m = 0; m < 4; m++) send(2'(m), 32'hFFFF_0000, 0, 32'h0001_0000, 0, 0);
		send(1, 0, 0, 0, 32'd200 << 16, 0);
		send(2, 32'h0001_0000, 32'h0001_0000, 32'h8000_0000, 32'h8000_0000, 0);
		drain();
		write_reg(REG_CENTER_GAIN, 32'hFFFF_FFFF);
		write_reg(REG_HALF_LENGTH, 32'hFFFF_FFFF);
		write_reg(REG_HALF_WIDTH, 32'hFFFF_FFFF);
		send(0, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 0, 0);
		send(3, 0, 0, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 0);
		drain();
		// receiver stalls while the sender keeps offering words
		hold_off = 400;
		for (int i = 0; i < 6; i++)
			send(2'($urandom_range(0, 3)), rnd_val(), rnd_val(), rnd_val(), rnd_val(), 0);
		for (int ph = 0; ph < 8; ph++) begin
			drain();
			write_reg(REG_CENTER_GAIN, ph == 7 ? 0 : ($urandom_range(0, 3) == 0 ?
				32'hFFFF_FFFF : $urandom_range(0, 4 * 65536)));
			write_reg(REG_HALF_LENGTH, rnd_geom());
			write_reg(REG_HALF_WIDTH, rnd_geom());
			write_reg(REG_FLIP_ENABLE, 32'(ph[0]));
			write_reg(8'(4 + ph), $urandom());
			for (int i = 0; i < 160; i++)
				send(2'($urandom_range(0, 3)), rnd_val(), rnd_val(),
					$urandom_range(0, 3) == 0 ? 0 : rnd_val(),
					$urandom_range(0, 1) ? rnd_val() : $urandom(), 1);
		end
		drain();
		if (sb.errors == 0)
			$display("swerve_inverse_kinematics_tb: clean");
		else
			$display("swerve_inverse_kinematics_tb: errors");
		$finish;
	end
endmodule
